@@ rtl/assert_macros.svh @@
// Assertion macros used by the dimmer menu controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that a trigger in one cycle is followed by a condition in the next.
`define ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

@@ rtl/dmc_pkg.sv @@
// Types and constants shared by the dimmer menu controller modules.
`timescale 1ns / 1ps

package dmc_pkg;

	localparam int IDLE_W   = 5;
	localparam int SAMPLE_W = 10;
	localparam int LEVEL_W  = 4;
	localparam int PRESET_W = 2;
	localparam int MARK_W   = 10;
	localparam int DSPACE_W = 10;
	localparam int PSPACE_W = 9;

	localparam logic [IDLE_W-1:0]   TIMEOUT_RESET = 5'd30;
	localparam logic [LEVEL_W-1:0]  LEVEL_MIN     = 4'd1;
	localparam logic [LEVEL_W-1:0]  LEVEL_MAX     = 4'd10;
	localparam logic [LEVEL_W-1:0]  LEVEL_RESET   = 4'd5;
	localparam logic [PRESET_W-1:0] PRESET_MIN    = 2'd1;
	localparam logic [PRESET_W-1:0] PRESET_MAX    = 2'd3;
	localparam logic [PRESET_W-1:0] PRESET_RESET  = 2'd1;
	localparam int                  AUTO_STEP     = 81;

	typedef enum logic [2:0] {
		MENU_OFF  = 3'd0,
		MENU_ON   = 3'd1,
		MENU_ADJ  = 3'd2,
		MENU_PRE  = 3'd3,
		MENU_AUTO = 3'd4
	} menu_state_t;

	typedef enum logic [1:0] {
		DRV_NONE = 2'd0,
		DRV_DIM  = 2'd1,
		DRV_PRE  = 2'd2,
		DRV_AUTO = 2'd3
	} drive_t;

	typedef enum logic [2:0] {
		EV_OFF  = 3'd0,
		EV_ON   = 3'd1,
		EV_ADJ  = 3'd2,
		EV_PRE  = 3'd3,
		EV_AUTO = 3'd4,
		EV_INC  = 3'd5,
		EV_DEC  = 3'd6,
		EV_TMO  = 3'd7
	} event_t;

	typedef struct packed {
		menu_state_t         menu;
		drive_t              drive;
		logic [LEVEL_W-1:0]  level;
		logic [PRESET_W-1:0] preset;
	} dmc_state_t;

	typedef struct packed {
		logic [MARK_W-1:0]   dim_mark;
		logic [DSPACE_W-1:0] dim_space;
		logic [MARK_W-1:0]   preset_mark;
		logic [PSPACE_W-1:0] preset_space;
	} dmc_leds_t;

endpackage

@@ rtl/dmc_tick_if.sv @@
// Tick input channel: button levels and light sample with valid/ready.
`timescale 1ns / 1ps

interface dmc_tick_if;
	import dmc_pkg::*;

	logic                valid;
	logic                ready;
	logic                on_off_pressed;
	logic                select_pressed;
	logic                inc_pressed;
	logic                dec_pressed;
	logic [SAMPLE_W-1:0] light_sample;

	modport source (
		output valid, on_off_pressed, select_pressed, inc_pressed, dec_pressed, light_sample,
		input  ready
	);

	modport sink (
		input  valid, on_off_pressed, select_pressed, inc_pressed, dec_pressed, light_sample,
		output ready
	);

endinterface

@@ rtl/dmc_result_if.sv @@
// Result output channel: menu state, level, preset and LED timings with valid/ready.
`timescale 1ns / 1ps

interface dmc_result_if;
	import dmc_pkg::*;

	logic                valid;
	logic                ready;
	logic [2:0]          menu_state;
	logic [LEVEL_W-1:0]  level;
	logic [PRESET_W-1:0] preset_sel;
	logic [MARK_W-1:0]   dim_mark;
	logic [DSPACE_W-1:0] dim_space;
	logic [MARK_W-1:0]   preset_mark;
	logic [PSPACE_W-1:0] preset_space;

	modport source (
		output valid, menu_state, level, preset_sel, dim_mark, dim_space, preset_mark,
			preset_space,
		input  ready
	);

	modport sink (
		input  valid, menu_state, level, preset_sel, dim_mark, dim_space, preset_mark,
			preset_space,
		output ready
	);

endinterface

@@ rtl/dmc_menu_core.sv @@
// Menu state registers, button event decode and next-state logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmc_menu_core
	import dmc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDLE_W-1:0]   cfg_wdata,
	input  logic                step,
	input  logic                on_off_pressed,
	input  logic                select_pressed,
	input  logic                inc_pressed,
	input  logic                dec_pressed,
	input  logic [SAMPLE_W-1:0] light_sample,
	output dmc_state_t          state_next
);

	logic [IDLE_W-1:0] timeout_q;
	logic [IDLE_W-1:0] idle_q;
	dmc_state_t        state_q;

	logic [IDLE_W-1:0] idle_inc;
	logic [IDLE_W-1:0] idle_next;
	logic              any_pressed;
	event_t            ev;
	dmc_state_t        st_btn;
	dmc_state_t        st_tmo;
	logic [IDLE_W-1:0] idle_btn;

	// The level is the number of whole steps in the sample, held to 1..10.
	function automatic logic [LEVEL_W-1:0] auto_level(input logic [SAMPLE_W-1:0] sample);
		logic [LEVEL_W-1:0] lvl;
		lvl = LEVEL_MIN;
		for (int k = 2; k <= int'(LEVEL_MAX); k++) begin
			if (sample >= SAMPLE_W'(AUTO_STEP * k)) begin
				lvl = LEVEL_W'(k);
			end
		end
		return lvl;
	endfunction

	function automatic dmc_state_t run_menu(
		input dmc_state_t          cur,
		input event_t              e,
		input logic                inc,
		input logic                dec,
		input logic [SAMPLE_W-1:0] sample
	);
		dmc_state_t  nxt;
		menu_state_t nx;
		nxt = cur;
		nx  = cur.menu;
		unique case (cur.menu)
			MENU_OFF: begin
				if (e == EV_ON) nx = MENU_ON;
			end
			MENU_ON: begin
				if (e == EV_ADJ) nx = MENU_ADJ;
				else if (e == EV_OFF) nx = MENU_OFF;
			end
			MENU_ADJ: begin
				if (e == EV_PRE) nx = MENU_PRE;
				else if (e == EV_OFF) nx = MENU_OFF;
				else if (e == EV_TMO) nx = MENU_ON;
			end
			MENU_PRE: begin
				if (e == EV_AUTO) nx = MENU_AUTO;
				else if (e == EV_OFF) nx = MENU_OFF;
				else if (e == EV_TMO) nx = MENU_ON;
			end
			MENU_AUTO: begin
				if (e == EV_ADJ) nx = MENU_ADJ;
				else if (e == EV_OFF) nx = MENU_OFF;
				else if (e == EV_TMO) nx = MENU_ON;
			end
			default: begin
				nx = cur.menu;
			end
		endcase
		// Returning to on keeps the drive mode, so the LEDs stay lit after a timeout.
		if (nx != cur.menu) begin
			unique case (nx)
				MENU_OFF:  nxt.drive = DRV_NONE;
				MENU_ADJ:  nxt.drive = DRV_DIM;
				MENU_PRE:  nxt.drive = DRV_PRE;
				MENU_AUTO: nxt.drive = DRV_AUTO;
				default:   nxt.drive = cur.drive;
			endcase
		end
		nxt.menu = nx;
		unique case (nx)
			MENU_ADJ: begin
				if (inc) nxt.level = (nxt.level >= LEVEL_MAX) ? LEVEL_MAX : nxt.level + 4'd1;
				if (dec) nxt.level = (nxt.level <= LEVEL_MIN) ? LEVEL_MIN : nxt.level - 4'd1;
			end
			MENU_PRE: begin
				if (inc) nxt.preset = (nxt.preset >= PRESET_MAX) ? PRESET_MAX : nxt.preset + 2'd1;
				if (dec) nxt.preset = (nxt.preset <= PRESET_MIN) ? PRESET_MIN : nxt.preset - 2'd1;
			end
			MENU_AUTO: begin
				nxt.level = auto_level(sample);
			end
			default: begin
				nxt.level = cur.level;
			end
		endcase
		return nxt;
	endfunction

	assign idle_inc    = idle_q + 5'd1;
	assign any_pressed = on_off_pressed | select_pressed | inc_pressed | dec_pressed;

	// A pending timeout outranks every button.
	always_comb begin
		priority if (idle_inc >= timeout_q) begin
			ev = EV_TMO;
		end else if (on_off_pressed) begin
			ev = (state_q.menu != MENU_OFF) ? EV_OFF : EV_ON;
		end else if (select_pressed) begin
			priority if (state_q.menu == MENU_ON) ev = EV_ADJ;
			else if (state_q.menu == MENU_ADJ) ev = EV_PRE;
			else if (state_q.menu == MENU_PRE) ev = EV_AUTO;
			else ev = EV_ADJ;
		end else if (inc_pressed) begin
			ev = EV_INC;
		end else begin
			ev = EV_DEC;
		end
	end

	always_comb begin
		if (any_pressed) begin
			st_btn   = run_menu(state_q, ev, inc_pressed, dec_pressed, light_sample);
			idle_btn = '0;
		end else begin
			st_btn   = state_q;
			idle_btn = idle_inc;
		end

		if (idle_btn >= timeout_q && st_btn.menu != MENU_ON && st_btn.menu != MENU_OFF) begin
			st_tmo    = run_menu(st_btn, EV_TMO, inc_pressed, dec_pressed, light_sample);
			idle_next = '0;
		end else begin
			st_tmo    = st_btn;
			idle_next = idle_btn;
		end

		state_next = st_tmo;
		if (st_tmo.drive == DRV_AUTO && st_tmo.menu != MENU_OFF) begin
			state_next.level = auto_level(light_sample);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			idle_q    <= '0;
			state_q   <= '{menu: MENU_OFF, drive: DRV_NONE, level: LEVEL_RESET,
				preset: PRESET_RESET};
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (step) begin
				idle_q  <= idle_next;
				state_q <= state_next;
			end
		end
	end

	`ASSERT_ALWAYS(a_off_undriven, state_q.menu != MENU_OFF || state_q.drive == DRV_NONE, "menu off with an LED driven")
	`ASSERT_ALWAYS(a_auto_drive_menu, state_q.drive != DRV_AUTO || state_q.menu == MENU_ON || state_q.menu == MENU_AUTO, "auto drive outside on or auto menu")
	`ASSERT_ALWAYS(a_level_range, state_q.level >= LEVEL_MIN && state_q.level <= LEVEL_MAX, "level out of range")
	`ASSERT_NEXT(a_hold_without_step, !step, $stable(state_q) && $stable(idle_q), "state moved without a transaction")

endmodule

@@ rtl/dmc_drive_map.sv @@
// Maps menu state, level and preset to the mark and space widths of both LEDs.
`timescale 1ns / 1ps

module dmc_drive_map
	import dmc_pkg::*;
(
	input  dmc_state_t st,
	output dmc_leds_t  leds
);

	logic dim_on;
	logic pre_on;

	function automatic logic [MARK_W-1:0] dim_mark_of(input logic [LEVEL_W-1:0] lvl);
		logic [MARK_W-1:0] v;
		unique case (lvl)
			4'd2:    v = 10'd20;
			4'd3:    v = 10'd30;
			4'd4:    v = 10'd40;
			4'd5:    v = 10'd50;
			4'd6:    v = 10'd60;
			4'd7:    v = 10'd70;
			4'd8:    v = 10'd80;
			4'd9:    v = 10'd100;
			4'd10:   v = 10'd1000;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [DSPACE_W-1:0] dim_space_of(input logic [LEVEL_W-1:0] lvl);
		logic [DSPACE_W-1:0] v;
		unique case (lvl)
			4'd2:    v = 10'd600;
			4'd3:    v = 10'd500;
			4'd4:    v = 10'd400;
			4'd5:    v = 10'd400;
			4'd6:    v = 10'd350;
			4'd7:    v = 10'd250;
			4'd8:    v = 10'd200;
			4'd9:    v = 10'd50;
			4'd10:   v = 10'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [MARK_W-1:0] pre_mark_of(input logic [PRESET_W-1:0] p);
		logic [MARK_W-1:0] v;
		unique case (p)
			2'd1:    v = 10'd10;
			2'd2:    v = 10'd50;
			2'd3:    v = 10'd1000;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [PSPACE_W-1:0] pre_space_of(input logic [PRESET_W-1:0] p);
		logic [PSPACE_W-1:0] v;
		unique case (p)
			2'd1:    v = 9'd400;
			2'd2:    v = 9'd100;
			2'd3:    v = 9'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	// The auto drive shares the dimmed LED with brightness adjust.
	assign dim_on = (st.drive == DRV_DIM || st.drive == DRV_AUTO) && st.menu != MENU_OFF
		&& st.level <= LEVEL_MAX;
	assign pre_on = st.drive == DRV_PRE && st.menu != MENU_OFF && st.preset <= PRESET_MAX;

	always_comb begin
		leds.dim_mark     = dim_on ? dim_mark_of(st.level) : '0;
		leds.dim_space    = dim_on ? dim_space_of(st.level) : '0;
		leds.preset_mark  = pre_on ? pre_mark_of(st.preset) : '0;
		leds.preset_space = pre_on ? pre_space_of(st.preset) : '0;
	end

endmodule

@@ rtl/dimmer_menu_controller.sv @@
// Top level of the lamp dimmer menu controller.
// The menu update is one pass between the input and result registers.
// Throughput: one tick per cycle while result_out.ready is high.
// Reset (arst_n low, asynchronous): menu off, LEDs undriven, level 5, preset 1, timeout 30.
`timescale 1ns / 1ps

module dimmer_menu_controller
	import dmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDLE_W-1:0] cfg_wdata,
	dmc_tick_if.sink          tick_in,
	dmc_result_if.source      result_out
);

	logic                valid_s1;
	logic                on_off_s1;
	logic                select_s1;
	logic                inc_s1;
	logic                dec_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	logic                valid_s2;
	dmc_state_t          state_s2;
	dmc_leds_t           leds_s2;

	logic                load_s2;
	logic                accept_in;
	dmc_state_t          state_next;
	dmc_leds_t           leds_next;

	// The menu state advances only when a tick moves into the result register.
	assign load_s2       = valid_s1 && (!valid_s2 || result_out.ready);
	assign tick_in.ready = !valid_s1 || load_s2;
	assign accept_in     = tick_in.valid && tick_in.ready;

	dmc_menu_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.step           (load_s2),
		.on_off_pressed (on_off_s1),
		.select_pressed (select_s1),
		.inc_pressed    (inc_s1),
		.dec_pressed    (dec_s1),
		.light_sample   (sample_s1),
		.state_next     (state_next)
	);

	dmc_drive_map u_map (
		.st   (state_next),
		.leds (leds_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept_in) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (result_out.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			on_off_s1 <= tick_in.on_off_pressed;
			select_s1 <= tick_in.select_pressed;
			inc_s1    <= tick_in.inc_pressed;
			dec_s1    <= tick_in.dec_pressed;
			sample_s1 <= tick_in.light_sample;
		end
		if (load_s2) begin
			state_s2 <= state_next;
			leds_s2  <= leds_next;
		end
	end

	assign result_out.valid        = valid_s2;
	assign result_out.menu_state   = state_s2.menu;
	assign result_out.level        = state_s2.level;
	assign result_out.preset_sel   = state_s2.preset;
	assign result_out.dim_mark     = leds_s2.dim_mark;
	assign result_out.dim_space    = leds_s2.dim_space;
	assign result_out.preset_mark  = leds_s2.preset_mark;
	assign result_out.preset_space = leds_s2.preset_space;

endmodule
